// ----- hw/rtl/mpcg_pkg.sv -----
package mpcg_pkg;

  localparam int KIND_W     = 3;
  localparam int READ_W     = 24;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 12;
  localparam int GAIN_W     = 23;
  localparam int WATTH_W    = 16;
  localparam int GAIN_OUT_W = 32;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  // watth * 100 and the full product gain * watth * 100
  localparam int WH_W      = WATTH_W + 7;
  localparam int NUM_W     = GAIN_W + WH_W;
  localparam int MUL_STEPS = GAIN_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(NUM_W);

  localparam int WARMUP_PULSES  = 320;
  localparam int MEASURE_PULSES = 3200;

  localparam logic [GAIN_W-1:0]  GAIN_LOW      = 23'h200000;
  localparam logic [GAIN_W-1:0]  GAIN_HIGH     = 23'h600000;
  localparam logic [GAIN_W-1:0]  GAIN_DEFAULT  = 23'h400000;
  localparam logic [WATTH_W-1:0] WATTH_DEFAULT = 16'd2000;

  // watt error window of -2 to +3 expressed on the raw sum
  localparam int ERR_LO = 200;
  localparam int ERR_HI = 300;

  localparam logic [KIND_W-1:0] KIND_PULSE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CALC    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENABLE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;

  localparam logic [STAT_W-1:0] STAT_NONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RETRY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ACCEPT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATTH = 1'd1;

endpackage

// ----- hw/rtl/mpcg_chan_if.sv -----
interface mpcg_in_if import mpcg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [READ_W-1:0] energy_reading;
  logic [SUM_W-1:0]         accum_value;

  modport source (output valid, kind, energy_reading, accum_value, input ready);
  modport sink (input valid, kind, energy_reading, accum_value, output ready);
endinterface

interface mpcg_out_if import mpcg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  measure_done;
  logic [SUM_W-1:0]      accumulated;
  logic [CNT_W-1:0]      pulse_count;
  logic [GAIN_OUT_W-1:0] gain_out;
  logic [STAT_W-1:0]     calc_status;
  logic                  cal_enabled;

  modport source (output valid, measure_done, accumulated, pulse_count, gain_out,
                  calc_status, cal_enabled, input ready);
  modport sink (input valid, measure_done, accumulated, pulse_count, gain_out,
                calc_status, cal_enabled, output ready);
endinterface

// ----- hw/rtl/meter_pulse_calibration_gain_core.sv -----
// Gain calibration from reference meter pulses. One result comes back for every item taken.
// Pulse, enable, disable and restart items execute in ST_EXEC and are registered once the output
// is free; a calculate item runs the bit-serial multiplier (23 steps, one gain bit
// per cycle) and the restoring divider (46 steps, one quotient bit per cycle) that share one
// 46-bit work register. One item is in work at a time; the next item is taken as soon as the
// block is back in idle, even while the previous result still waits in the output register.
// The configuration registers are loaded into the working gain and watt-hour reference only
// by an enable item.
module meter_pulse_calibration_gain_core import mpcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mpcg_in_if.sink               in_chan,
  mpcg_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_CALC} state_t;
  typedef enum logic [1:0] {PH_WARMUP, PH_MEASURE, PH_DONE} phase_t;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  en_r, en_nxt;
  logic [GAIN_W-1:0]     gain_r, gain_nxt;
  logic [WATTH_W-1:0]    watth_r, watth_nxt;
  logic [GAIN_W-1:0]     init_gain_r, init_gain_nxt;
  logic [WATTH_W-1:0]    ref_watth_r, ref_watth_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [READ_W-1:0]     reading_r, reading_nxt;
  logic [SUM_W-1:0]      accum_r, accum_nxt;
  logic [WH_W-1:0]       wh100_r, wh100_nxt;
  logic [GAIN_W-1:0]     mplier_r, mplier_nxt;
  logic [NUM_W-1:0]      work_r, work_nxt;
  logic [SUM_W-1:0]      rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_done_r, out_done_nxt;
  logic [SUM_W-1:0]      out_sum_r, out_sum_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic [GAIN_OUT_W-1:0] out_gain_r, out_gain_nxt;
  logic [STAT_W-1:0]     out_stat_r, out_stat_nxt;
  logic                  out_en_r, out_en_nxt;

  logic                  out_free;
  logic [SUM_W-1:0]      reading_ext;
  logic [CNT_W-1:0]      cnt_inc;
  logic [SUM_W-1:0]      meas_sum;
  logic [CNT_W-1:0]      meas_cnt;
  logic [WH_W-1:0]       wh100_calc;
  logic [NUM_W-1:0]      mul_add;
  logic [SUM_W:0]        div_trial;
  logic [SUM_W:0]        div_diff;
  logic                  div_ge;
  logic                  q_in_range;
  logic                  lo_ok;
  logic                  hi_ok;
  logic                  pulse_done;

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.measure_done = out_done_r;
  assign out_chan.accumulated  = out_sum_r;
  assign out_chan.pulse_count  = out_cnt_r;
  assign out_chan.gain_out     = out_gain_r;
  assign out_chan.calc_status  = out_stat_r;
  assign out_chan.cal_enabled  = out_en_r;

  assign out_free    = !out_valid_r || out_chan.ready;
  assign reading_ext = {{(SUM_W-READ_W){reading_r[READ_W-1]}}, reading_r};
  assign cnt_inc     = cnt_r + 1'b1;

  // measure phase update
  always_comb begin
    meas_sum = (cnt_r == '0) ? '0 : sum_r;
    meas_cnt = cnt_r;
    if (!reading_r[READ_W-1]) begin
      meas_sum = meas_sum + reading_ext;
      meas_cnt = cnt_inc;
    end
  end

  // watth * 100 = watth * 64 + watth * 32 + watth * 4
  assign wh100_calc = WH_W'({watth_r, 6'b0}) + WH_W'({watth_r, 5'b0})
                    + WH_W'({watth_r, 2'b0});

  assign mul_add = {work_r[NUM_W-2:0], 1'b0}
                 + (mplier_r[GAIN_W-1] ? NUM_W'(wh100_r) : '0);

  assign div_trial = {rem_r, work_r[NUM_W-1]};
  assign div_diff  = div_trial - {1'b0, accum_r};
  assign div_ge    = (div_trial >= {1'b0, accum_r});

  assign q_in_range = (work_r[NUM_W-1:GAIN_W] == '0)
                   && (work_r[GAIN_W-1:0] >= GAIN_LOW)
                   && (work_r[GAIN_W-1:0] <= GAIN_HIGH);
  assign lo_ok = (wh100_r < WH_W'(ERR_LO))
              || (accum_r >= SUM_W'(wh100_r - WH_W'(ERR_LO)));
  assign hi_ok = (accum_r < (SUM_W'(wh100_r) + SUM_W'(ERR_HI)));

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    en_nxt        = en_r;
    gain_nxt      = gain_r;
    watth_nxt     = watth_r;
    init_gain_nxt = init_gain_r;
    ref_watth_nxt = ref_watth_r;
    kind_nxt      = kind_r;
    reading_nxt   = reading_r;
    accum_nxt     = accum_r;
    wh100_nxt     = wh100_r;
    mplier_nxt    = mplier_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_done_nxt  = out_done_r;
    out_sum_nxt   = out_sum_r;
    out_cnt_nxt   = out_cnt_r;
    out_gain_nxt  = out_gain_r;
    out_stat_nxt  = out_stat_r;
    out_en_nxt    = out_en_r;
    pulse_done    = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:  init_gain_nxt = cfg_wdata[GAIN_W-1:0];
        CFG_WATTH: ref_watth_nxt = cfg_wdata[WATTH_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt    = in_chan.kind;
          reading_nxt = in_chan.energy_reading;
          accum_nxt   = in_chan.accum_value;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (kind_r == KIND_CALC) begin
          wh100_nxt  = wh100_calc;
          mplier_nxt = gain_r;
          work_nxt   = '0;
          step_nxt   = '0;
          state_nxt  = ST_MUL;
        end else if (out_free) begin
          case (kind_r)
            KIND_PULSE: begin
              if (en_r) begin
                case (phase_r)
                  PH_WARMUP: begin
                    sum_nxt = reading_ext;
                    cnt_nxt = cnt_inc;
                    if (cnt_inc > CNT_W'(WARMUP_PULSES)) begin
                      cnt_nxt   = '0;
                      sum_nxt   = '0;
                      phase_nxt = PH_MEASURE;
                    end
                  end
                  PH_MEASURE: begin
                    sum_nxt = meas_sum;
                    cnt_nxt = meas_cnt;
                    if (meas_cnt > CNT_W'(MEASURE_PULSES)) begin
                      pulse_done = 1'b1;
                      phase_nxt  = PH_DONE;
                    end
                  end
                  PH_DONE: ;
                  default: phase_nxt = PH_WARMUP;
                endcase
              end
            end
            KIND_ENABLE: begin
              gain_nxt  = init_gain_r;
              watth_nxt = ref_watth_r;
              cnt_nxt   = '0;
              en_nxt    = 1'b1;
            end
            KIND_DISABLE: begin
              if (en_r) begin
                cnt_nxt = '0;
                en_nxt  = 1'b0;
              end
            end
            KIND_RESTART: cnt_nxt = '0;
            default: ;
          endcase
          out_valid_nxt = 1'b1;
          out_done_nxt  = pulse_done;
          out_sum_nxt   = sum_nxt;
          out_cnt_nxt   = cnt_nxt;
          out_gain_nxt  = GAIN_OUT_W'(gain_nxt);
          out_stat_nxt  = STAT_NONE;
          out_en_nxt    = en_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MUL: begin
        work_nxt   = mul_add;
        mplier_nxt = {mplier_r[GAIN_W-2:0], 1'b0};
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_diff[SUM_W-1:0] : div_trial[SUM_W-1:0];
        work_nxt = {work_r[NUM_W-2:0], div_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (out_free) begin
          cnt_nxt = '0;
          if ((accum_r == '0) || !q_in_range) begin
            gain_nxt     = GAIN_DEFAULT;
            watth_nxt    = WATTH_DEFAULT;
            phase_nxt    = PH_WARMUP;
            out_gain_nxt = GAIN_OUT_W'(GAIN_DEFAULT);
            out_stat_nxt = STAT_RANGE;
          end else begin
            gain_nxt     = work_r[GAIN_W-1:0];
            out_gain_nxt = work_r[GAIN_OUT_W-1:0];
            if (lo_ok && hi_ok) begin
              en_nxt       = 1'b0;
              out_stat_nxt = STAT_ACCEPT;
            end else begin
              phase_nxt    = PH_WARMUP;
              out_stat_nxt = STAT_RETRY;
            end
          end
          out_valid_nxt = 1'b1;
          out_done_nxt  = 1'b0;
          out_sum_nxt   = sum_r;
          out_cnt_nxt   = cnt_nxt;
          out_en_nxt    = en_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_WARMUP;
      cnt_r       <= '0;
      sum_r       <= '0;
      en_r        <= 1'b0;
      gain_r      <= GAIN_DEFAULT;
      watth_r     <= WATTH_DEFAULT;
      init_gain_r <= GAIN_DEFAULT;
      ref_watth_r <= WATTH_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      en_r        <= en_nxt;
      gain_r      <= gain_nxt;
      watth_r     <= watth_nxt;
      init_gain_r <= init_gain_nxt;
      ref_watth_r <= ref_watth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    reading_r  <= reading_nxt;
    accum_r    <= accum_nxt;
    wh100_r    <= wh100_nxt;
    mplier_r   <= mplier_nxt;
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_done_r <= out_done_nxt;
    out_sum_r  <= out_sum_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_gain_r <= out_gain_nxt;
    out_stat_r <= out_stat_nxt;
    out_en_r   <= out_en_nxt;
  end

endmodule

// ----- hw/rtl/mpcg_checker.sv -----
module mpcg_checker import mpcg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_measure_done,
  input logic [SUM_W-1:0]      out_accumulated,
  input logic [CNT_W-1:0]      out_pulse_count,
  input logic [GAIN_OUT_W-1:0] out_gain_out,
  input logic [STAT_W-1:0]     out_calc_status,
  input logic                  out_cal_enabled
);

  // one item in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transfer taken while previous item still in work");

  a_range_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_calc_status == STAT_RANGE)) |->
      ((out_gain_out == GAIN_OUT_W'(GAIN_DEFAULT)) && (out_pulse_count == '0)))
    else $error("range reset result without default gain");

  a_accept_disables: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_calc_status == STAT_ACCEPT)) |->
      (!out_cal_enabled && (out_pulse_count == '0)))
    else $error("accepted calibration left enabled");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_measure_done) |->
      ((out_pulse_count > CNT_W'(MEASURE_PULSES)) && out_cal_enabled
       && (out_calc_status == STAT_NONE)))
    else $error("measure done with short count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_accumulated) && $stable(out_gain_out)
       && $stable(out_pulse_count) && $stable(out_calc_status)))
    else $error("stalled result changed");

endmodule

bind meter_pulse_calibration_gain_core mpcg_checker u_mpcg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_measure_done (out_chan.measure_done),
  .out_accumulated  (out_chan.accumulated),
  .out_pulse_count  (out_chan.pulse_count),
  .out_gain_out     (out_chan.gain_out),
  .out_calc_status  (out_chan.calc_status),
  .out_cal_enabled  (out_chan.cal_enabled)
);
